/* src/rdd_pkg.sv */
// shared types, constants and helper functions for the resource deadlock detector
`default_nettype none
package rdd_pkg;

	localparam int DEF_NUM_PROC = 8;
	localparam int DEF_NUM_RES = 4;
	localparam int NUM_FIELDS = 4;
	localparam int AMT_W = 8;
	localparam int CMD_W = 2;
	localparam int PID_W = 3;
	localparam int MASK_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DETECT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [PID_W-1:0] process_id;
		logic [AMT_W-1:0] amount_r0;
		logic [AMT_W-1:0] amount_r1;
		logic [AMT_W-1:0] amount_r2;
		logic [AMT_W-1:0] amount_r3;
	} item_t;

	typedef struct packed {
		logic granted;
		logic all_reduced;
		logic [MASK_W-1:0] deadlocked_mask;
		logic release_error;
	} result_t;

	typedef struct packed {
		logic latch;
		logic apply;
		logic scan_en;
		logic finish_det;
	} ctl_t;

	typedef struct packed {
		logic det_stop;
	} sts_t;

	function automatic logic [AMT_W-1:0] item_amount(item_t it, int j);
		logic [AMT_W-1:0] a;
		case (j)
			0: a = it.amount_r0;
			1: a = it.amount_r1;
			2: a = it.amount_r2;
			3: a = it.amount_r3;
			default: a = '0;
		endcase
		return a;
	endfunction

	function automatic logic [AMT_W-1:0] sat_add(logic [AMT_W-1:0] a, logic [AMT_W-1:0] b);
		logic [AMT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[AMT_W] ? {AMT_W{1'b1}} : s[AMT_W-1:0];
	endfunction

endpackage
`default_nettype wire

/* src/rdd_ctrl.sv */
// command sequencer for the resource deadlock detector
`default_nettype none
module rdd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rdd_pkg::CMD_W-1:0] cmd,
	input wire rdd_pkg::sts_t sts,
	output logic busy,
	output rdd_pkg::ctl_t ctl
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_SCAN = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic accept;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.latch = accept;
				if (accept) begin
					priority if (cmd == rdd_pkg::CMD_DETECT) begin
						state_d = ST_SCAN;
					end else if (cmd == rdd_pkg::CMD_RELOAD) begin
						state_d = ST_APPLY;
					end else begin
						state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_APPLY;
			end
			ST_APPLY: begin
				ctl.apply = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (sts.det_stop) begin
					ctl.finish_det = 1'b1;
					state_d = ST_IDLE;
				end else begin
					ctl.scan_en = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* src/rdd_datapath.sv */
// matrices, available vector, reduction scan and result register
`default_nettype none
module rdd_datapath #(
	parameter int NUM_PROC = rdd_pkg::DEF_NUM_PROC,
	parameter int NUM_RES = rdd_pkg::DEF_NUM_RES
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rdd_pkg::item_t item,
	input wire rdd_pkg::ctl_t ctl,
	output rdd_pkg::sts_t sts,
	input wire logic cfg_we,
	input wire logic [rdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [rdd_pkg::AMT_W-1:0] cfg_data,
	output rdd_pkg::result_t result,
	output logic done
);

	localparam int AW = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
	localparam int QW = $clog2(NUM_PROC + 1);
	localparam int W = rdd_pkg::AMT_W;

	typedef logic [NUM_RES-1:0][W-1:0] row_t;

	logic [rdd_pkg::NUM_FIELDS-1:0][W-1:0] cap_q;
	row_t avail_q;
	rdd_pkg::item_t item_q;
	row_t alloc_mem [NUM_PROC];
	row_t pend_mem [NUM_PROC];
	logic [NUM_PROC-1:0] row_vld_q;
	row_t alloc_s1;
	row_t pend_s1;
	logic rvld_s1;
	row_t work_q;
	logic [NUM_PROC-1:0] pdone_q;
	logic [QW-1:0] quiet_q;
	logic [AW-1:0] rd_idx_q;
	logic [AW-1:0] ev_idx_s1;
	logic ev_vld_s1;
	rdd_pkg::result_t result_q;
	logic done_q;

	logic [AW+rdd_pkg::PID_W-1:0] pid_ext;
	logic [AW-1:0] pid_addr;
	logic pid_ok;
	logic [AW-1:0] rd_addr;
	row_t alloc_eff;
	row_t pend_eff;
	row_t amt;
	row_t cap_row;
	logic fits;
	logic rel_err;
	row_t req_alloc;
	row_t req_pend;
	row_t req_avail;
	row_t rel_alloc;
	row_t rel_avail;
	row_t work_add;
	logic pend_fits;
	logic ev_step;
	logic ev_ok;
	logic mem_we;
	logic is_req;
	logic is_rel;
	logic [rdd_pkg::MASK_W-1:0] mask;

	assign pid_ext = {{AW{1'b0}}, item_q.process_id};
	assign pid_addr = pid_ext[AW-1:0];
	assign pid_ok = (pid_ext < (AW + rdd_pkg::PID_W)'(NUM_PROC));
	assign rd_addr = ctl.scan_en ? rd_idx_q : pid_addr;
	assign alloc_eff = rvld_s1 ? alloc_s1 : '0;
	assign pend_eff = rvld_s1 ? pend_s1 : '0;
	assign is_req = (item_q.cmd == rdd_pkg::CMD_REQUEST);
	assign is_rel = (item_q.cmd == rdd_pkg::CMD_RELEASE);

	always_comb begin
		fits = 1'b1;
		rel_err = 1'b0;
		pend_fits = 1'b1;
		for (int j = 0; j < NUM_RES; j++) begin
			amt[j] = rdd_pkg::item_amount(item_q, j);
			cap_row[j] = (j < rdd_pkg::NUM_FIELDS) ? cap_q[j] : '0;
			if (amt[j] > avail_q[j]) begin
				fits = 1'b0;
			end
			req_alloc[j] = rdd_pkg::sat_add(alloc_eff[j], amt[j]);
			req_pend[j] = rdd_pkg::sat_add(pend_eff[j], amt[j]);
			req_avail[j] = avail_q[j] - amt[j];
			if (amt[j] > alloc_eff[j]) begin
				rel_err = 1'b1;
				rel_alloc[j] = '0;
				rel_avail[j] = rdd_pkg::sat_add(avail_q[j], alloc_eff[j]);
			end else begin
				rel_alloc[j] = alloc_eff[j] - amt[j];
				rel_avail[j] = rdd_pkg::sat_add(avail_q[j], amt[j]);
			end
			work_add[j] = rdd_pkg::sat_add(work_q[j], alloc_eff[j]);
			if (pend_eff[j] > work_q[j]) begin
				pend_fits = 1'b0;
			end
		end
	end

	assign ev_step = ev_vld_s1 && ctl.scan_en;
	assign ev_ok = ev_step && !pdone_q[ev_idx_s1] && pend_fits;
	assign mem_we = ctl.apply && pid_ok && (is_req || is_rel);
	assign sts.det_stop = (quiet_q == QW'(NUM_PROC));

	always_comb begin
		mask = '0;
		for (int i = 0; i < rdd_pkg::MASK_W; i++) begin
			if (i < NUM_PROC) begin
				mask[i] = !pdone_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			alloc_mem[pid_addr] <= (is_req && fits) ? req_alloc : (is_rel ? rel_alloc : alloc_eff);
			pend_mem[pid_addr] <= (is_req && !fits) ? req_pend : pend_eff;
		end
		alloc_s1 <= alloc_mem[rd_addr];
		pend_s1 <= pend_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			item_q <= item;
			work_q <= avail_q;
		end else if (ev_ok) begin
			work_q <= work_add;
		end
		ev_idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			avail_q <= '0;
			row_vld_q <= '0;
			rvld_s1 <= 1'b0;
			pdone_q <= '0;
			quiet_q <= '0;
			rd_idx_q <= '0;
			ev_vld_s1 <= 1'b0;
			result_q <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q[cfg_index] <= cfg_data;
			end
			rvld_s1 <= row_vld_q[rd_addr];
			ev_vld_s1 <= ctl.scan_en;
			done_q <= ctl.apply || ctl.finish_det;
			if (ctl.latch) begin
				pdone_q <= '0;
				quiet_q <= '0;
				rd_idx_q <= '0;
			end else if (ctl.scan_en) begin
				rd_idx_q <= (rd_idx_q == AW'(NUM_PROC - 1)) ? '0 : rd_idx_q + 1'b1;
				if (ev_ok) begin
					pdone_q[ev_idx_s1] <= 1'b1;
					quiet_q <= '0;
				end else if (ev_step) begin
					quiet_q <= quiet_q + 1'b1;
				end
			end
			if (mem_we) begin
				row_vld_q[pid_addr] <= 1'b1;
			end
			if (ctl.apply) begin
				result_q.granted <= is_req && pid_ok && fits;
				result_q.all_reduced <= 1'b0;
				result_q.deadlocked_mask <= '0;
				result_q.release_error <= is_rel && pid_ok && rel_err;
				unique case (item_q.cmd)
					rdd_pkg::CMD_REQUEST: begin
						if (pid_ok && fits) begin
							avail_q <= req_avail;
						end
					end
					rdd_pkg::CMD_RELEASE: begin
						if (pid_ok) begin
							avail_q <= rel_avail;
						end
					end
					rdd_pkg::CMD_RELOAD: begin
						avail_q <= cap_row;
						row_vld_q <= '0;
					end
					default: begin
					end
				endcase
			end else if (ctl.finish_det) begin
				result_q.granted <= 1'b0;
				result_q.release_error <= 1'b0;
				result_q.all_reduced <= &pdone_q;
				result_q.deadlocked_mask <= mask;
			end
		end
	end

	assign result = result_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* src/resource_deadlock_detector_core.sv */
// top level of the resource deadlock detector
`default_nettype none
// Command port: an item transfers on a rising edge with start high and busy low.
// item.cmd selects request, release, detect or reload; busy stays high until the
// command completes. Each command returns one result, shown on result for exactly
// one cycle with done high; the receiver cannot stall, so a result is never held.
// Sequence from the transfer edge to the done cycle:
//   request, release: row fetch from the matrix memories, then update
//   reload: update only, with no row fetch
//   detect: set by the reduction scan, which evaluates one matrix row per cycle,
//     cycling over the rows until NUM_PROC evaluations in a row make no
//     progress.
// A new item is accepted in the cycle its predecessor's result is shown.
// Configuration: cfg_valid/cfg_ready write channel, ready always high; index i
// writes capacity of resource type i, picked up by available at the next reload.
// Reset clears capacities and available and invalidates both matrices (rows read as zero until
// written again, as after a reload).
module resource_deadlock_detector_core #(
	parameter int NUM_PROC = rdd_pkg::DEF_NUM_PROC,
	parameter int NUM_RES = rdd_pkg::DEF_NUM_RES
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire rdd_pkg::item_t item,
	output logic done,
	output rdd_pkg::result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [rdd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [rdd_pkg::AMT_W-1:0] cfg_data
);

	rdd_pkg::ctl_t ctl;
	rdd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rdd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(item.cmd),
		.sts(sts),
		.busy(busy),
		.ctl(ctl)
	);

	rdd_datapath #(
		.NUM_PROC(NUM_PROC),
		.NUM_RES(NUM_RES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.ctl(ctl),
		.sts(sts),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result(result),
		.done(done)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in progress");

	a_req_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (item.cmd == rdd_pkg::CMD_REQUEST ||
		item.cmd == rdd_pkg::CMD_RELEASE)) |-> ##3 done)
		else $error("request or release did not complete in three cycles");

	a_busy_from_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command transfer");

	a_one_result_field: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.granted) |-> (!result.release_error && !result.all_reduced))
		else $error("grant reported together with another command's field");

endmodule
`default_nettype wire
